// ===== hw/rtl/ordered_list_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list engine
// Concurrent checks clocked on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication
`define OLE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Types, sizes and codes shared by the ordered list engine and its cells.
// ----------------------------------------------------------------------------
package ole_pkg;

    // List capacity and derived widths
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RES_W = 5;
    localparam int VAL_W = 32;

    // Operation codes on the request channel
    localparam logic [2:0] ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] ACT_INS_TAIL  = 3'd1;
    localparam logic [2:0] ACT_DEL_FRONT = 3'd2;
    localparam logic [2:0] ACT_DEL_TAIL  = 3'd3;
    localparam logic [2:0] ACT_DEL_FIRST = 3'd4;
    localparam logic [2:0] ACT_DEL_ALL   = 3'd5;

    // Commands broadcast to every cell
    localparam logic [2:0] CMD_HOLD = 3'd0;
    localparam logic [2:0] CMD_SHR  = 3'd1;  // take left neighbour's entry
    localparam logic [2:0] CMD_SHL  = 3'd2;  // take right neighbour's entry
    localparam logic [2:0] CMD_TAIL = 3'd3;  // cell at the fill index loads value
    localparam logic [2:0] CMD_MARK = 3'd4;  // mark cells beyond the fill
    localparam logic [2:0] CMD_SCAN = 3'd5;  // token walks the chain, marks matches
    localparam logic [2:0] CMD_SORT = 3'd6;  // odd-even swap of marked cells

    typedef struct packed {
        logic [2:0]              action;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [RES_W-1:0] removed;
        logic [RES_W-1:0] count;
        logic             empty_res;
    } rsp_t;

    typedef struct packed {
        logic [2:0]              cmd;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        fill;
        logic                    all_mode;
        logic                    phase;
    } ctl_t;

endpackage

// ===== hw/rtl/ole_cell.sv =====
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds an entry and a removal mark, shifts to or from its
// neighbours, passes the scan token and match tally to the right.
// ----------------------------------------------------------------------------
module ole_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ole_pkg::ctl_t                    ctl,
    input  logic [ole_pkg::IDX_W-1:0]        idx,
    input  logic signed [ole_pkg::VAL_W-1:0] left_entry,
    input  logic                             left_mark,
    input  logic signed [ole_pkg::VAL_W-1:0] right_entry,
    input  logic                             right_mark,
    input  logic                             tok_in,
    input  logic [ole_pkg::CNT_W-1:0]        cnt_in,
    output logic signed [ole_pkg::VAL_W-1:0] entry,
    output logic                             mark,
    output logic                             tok,
    output logic [ole_pkg::CNT_W-1:0]        cnt
);

    logic signed [ole_pkg::VAL_W-1:0] entry_reg, entry_next;
    logic                             mark_reg, mark_next;
    logic                             tok_reg;
    logic [ole_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ole_pkg::CNT_W-1:0]        idx_ext;
    logic                             live;
    logic                             hit;
    logic                             left_role;

    assign idx_ext   = ole_pkg::CNT_W'(idx);
    assign live      = idx_ext < ctl.fill;
    // first-match mode stops once the tally shows an earlier hit
    assign hit       = tok_in && live && (entry_reg == ctl.value)
                       && (ctl.all_mode || (cnt_in == '0));
    assign left_role = (idx[0] == ctl.phase);

    // Next entry and mark per broadcast command
    always_comb
    begin
        entry_next = entry_reg;
        mark_next  = mark_reg;
        cnt_next   = cnt_reg;
        case (ctl.cmd)
            ole_pkg::CMD_SHR:
            begin
                entry_next = left_entry;
            end
            ole_pkg::CMD_SHL:
            begin
                entry_next = right_entry;
            end
            ole_pkg::CMD_TAIL:
            begin
                if (idx_ext == ctl.fill)
                begin
                    entry_next = ctl.value;
                end
            end
            ole_pkg::CMD_MARK:
            begin
                mark_next = !live;
            end
            ole_pkg::CMD_SCAN:
            begin
                mark_next = mark_reg | hit;
                cnt_next  = cnt_in + ole_pkg::CNT_W'(hit);
            end
            ole_pkg::CMD_SORT:
            begin
                // marked entries sink to the right, survivors keep order
                if (left_role)
                begin
                    if (mark_reg && !right_mark)
                    begin
                        entry_next = right_entry;
                        mark_next  = 1'b0;
                    end
                end
                else
                begin
                    if (left_mark && !mark_reg)
                    begin
                        entry_next = left_entry;
                        mark_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Scan token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else if (ctl.cmd == ole_pkg::CMD_SCAN)
        begin
            tok_reg <= tok_in;
        end
    end

    // Slot contents
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        mark_reg  <= mark_next;
        cnt_reg   <= cnt_next;
    end

    assign entry = entry_reg;
    assign mark  = mark_reg;
    assign tok   = tok_reg;
    assign cnt   = cnt_reg;

endmodule

// ===== hw/rtl/ordered_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Insert front/tail and delete front/tail: response registered from the request
//   transfer (or held in pend), one request per cycle while responses drain.
// Delete first/all matches: a token walks the DEPTH cells, then odd-even swap
//   steps run if anything matched; no new request meanwhile.
// Reset (rst_n low, asynchronous) empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_core_assert.svh"

module ordered_list_engine_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ole_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ole_pkg::rsp_t rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_SORT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [ole_pkg::CNT_W-1:0]        step_reg, step_next;
    logic [ole_pkg::CNT_W-1:0]        fill_reg, fill_next;
    logic signed [ole_pkg::VAL_W-1:0] val_reg, val_next;
    logic                             all_reg, all_next;
    logic [ole_pkg::CNT_W-1:0]        rem_reg, rem_next;
    ole_pkg::rsp_t                    pend_reg, pend_next;
    ole_pkg::rsp_t                    rsp_reg, rsp_next;
    logic                             rsp_valid_reg, rsp_valid_next;

    ole_pkg::ctl_t                    ctl;
    logic                             accept;
    logic                             slot_free;
    logic                             rsp_load;
    logic                             fin;
    logic                             fin_ok;
    logic [ole_pkg::CNT_W-1:0]        fin_rem;
    logic [ole_pkg::CNT_W-1:0]        fin_fill;
    ole_pkg::rsp_t                    fin_res;
    logic                             scan_start;

    logic signed [ole_pkg::VAL_W-1:0] cell_entry [ole_pkg::DEPTH];
    logic [ole_pkg::DEPTH-1:0]        cell_mark;
    logic [ole_pkg::DEPTH-1:0]        cell_tok;
    logic [ole_pkg::CNT_W-1:0]        cell_cnt   [ole_pkg::DEPTH];

    assign req_ready  = (state_reg == ST_IDLE);
    assign accept     = req_valid && req_ready;
    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign scan_start = (state_reg == ST_SCAN) && (step_reg == '0);

    // Sequencer and cell command
    always_comb
    begin
        ctl.cmd      = ole_pkg::CMD_HOLD;
        ctl.value    = (state_reg == ST_IDLE) ? req.value : val_reg;
        ctl.fill     = fill_reg;
        ctl.all_mode = all_reg;
        ctl.phase    = step_reg[0];

        state_next     = state_reg;
        step_next      = step_reg;
        fill_next      = fill_reg;
        val_next       = val_reg;
        all_next       = all_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_load       = 1'b0;

        fin      = 1'b0;
        fin_ok   = 1'b0;
        fin_rem  = '0;
        fin_fill = fill_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fin = 1'b1;
                    case (req.action)
                        ole_pkg::ACT_INS_FRONT:
                        begin
                            if (fill_reg < ole_pkg::CNT_W'(ole_pkg::DEPTH))
                            begin
                                ctl.cmd  = ole_pkg::CMD_SHR;
                                fin_ok   = 1'b1;
                                fin_fill = fill_reg + ole_pkg::CNT_W'(1);
                            end
                        end
                        ole_pkg::ACT_INS_TAIL:
                        begin
                            if (fill_reg < ole_pkg::CNT_W'(ole_pkg::DEPTH))
                            begin
                                ctl.cmd  = ole_pkg::CMD_TAIL;
                                fin_ok   = 1'b1;
                                fin_fill = fill_reg + ole_pkg::CNT_W'(1);
                            end
                        end
                        ole_pkg::ACT_DEL_FRONT:
                        begin
                            if (fill_reg != '0)
                            begin
                                ctl.cmd  = ole_pkg::CMD_SHL;
                                fin_ok   = 1'b1;
                                fin_rem  = ole_pkg::CNT_W'(1);
                                fin_fill = fill_reg - ole_pkg::CNT_W'(1);
                            end
                        end
                        ole_pkg::ACT_DEL_TAIL:
                        begin
                            if (fill_reg != '0)
                            begin
                                fin_ok   = 1'b1;
                                fin_rem  = ole_pkg::CNT_W'(1);
                                fin_fill = fill_reg - ole_pkg::CNT_W'(1);
                            end
                        end
                        ole_pkg::ACT_DEL_FIRST,
                        ole_pkg::ACT_DEL_ALL:
                        begin
                            fin        = 1'b0;
                            ctl.cmd    = ole_pkg::CMD_MARK;
                            state_next = ST_SCAN;
                            step_next  = '0;
                            val_next   = req.value;
                            all_next   = (req.action == ole_pkg::ACT_DEL_ALL);
                        end
                        default:
                        begin
                            fin_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ctl.cmd   = ole_pkg::CMD_SCAN;
                step_next = step_reg + ole_pkg::CNT_W'(1);
                // token has left the last cell: its tally is the match count
                if (step_reg == ole_pkg::CNT_W'(ole_pkg::DEPTH))
                begin
                    if (cell_cnt[ole_pkg::DEPTH-1] == '0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SORT;
                        step_next  = '0;
                        rem_next   = cell_cnt[ole_pkg::DEPTH-1];
                    end
                end
            end
            ST_SORT:
            begin
                ctl.cmd   = ole_pkg::CMD_SORT;
                step_next = step_reg + ole_pkg::CNT_W'(1);
                if (step_reg == ole_pkg::CNT_W'(ole_pkg::DEPTH - 1))
                begin
                    fin      = 1'b1;
                    fin_ok   = 1'b1;
                    fin_rem  = rem_reg;
                    fin_fill = fill_reg - rem_reg;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    rsp_load       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        fin_res.ok        = fin_ok;
        fin_res.removed   = ole_pkg::RES_W'(fin_rem);
        fin_res.count     = ole_pkg::RES_W'(fin_fill);
        fin_res.empty_res = (fin_fill == '0);

        // Finished operation goes to the output register or waits in pend
        if (fin)
        begin
            fill_next = fin_fill;
            if (slot_free)
            begin
                rsp_next       = fin_res;
                rsp_valid_next = 1'b1;
                rsp_load       = 1'b1;
                state_next     = ST_IDLE;
            end
            else
            begin
                pend_next  = fin_res;
                state_next = ST_HOLD;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Operands and results
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        all_reg  <= all_next;
        rem_reg  <= rem_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    // Cell chain
    for (genvar i = 0; i < ole_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [ole_pkg::VAL_W-1:0] l_entry;
        logic                             l_mark;
        logic signed [ole_pkg::VAL_W-1:0] r_entry;
        logic                             r_mark;
        logic                             t_in;
        logic [ole_pkg::CNT_W-1:0]        c_in;

        if (i == 0)
        begin : g_head
            assign l_entry = ctl.value;
            assign l_mark  = 1'b0;
            assign t_in    = scan_start;
            assign c_in    = '0;
        end
        else
        begin : g_body
            assign l_entry = cell_entry[i-1];
            assign l_mark  = cell_mark[i-1];
            assign t_in    = cell_tok[i-1];
            assign c_in    = cell_cnt[i-1];
        end

        if (i == ole_pkg::DEPTH - 1)
        begin : g_tail
            assign r_entry = '0;
            assign r_mark  = 1'b1;
        end
        else
        begin : g_inner
            assign r_entry = cell_entry[i+1];
            assign r_mark  = cell_mark[i+1];
        end

        ole_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .idx         (ole_pkg::IDX_W'(i)),
            .left_entry  (l_entry),
            .left_mark   (l_mark),
            .right_entry (r_entry),
            .right_mark  (r_mark),
            .tok_in      (t_in),
            .cnt_in      (c_in),
            .entry       (cell_entry[i]),
            .mark        (cell_mark[i]),
            .tok         (cell_tok[i]),
            .cnt         (cell_cnt[i])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `OLE_ASSERT_SAME(a_fill_range, 1'b1, fill_reg <= ole_pkg::CNT_W'(ole_pkg::DEPTH), "fill beyond capacity")
    `OLE_ASSERT_SAME(a_one_token, state_reg == ST_SCAN, $onehot0(cell_tok), "more than one scan token in the chain")
    `OLE_ASSERT_SAME(a_rem_bound, state_reg == ST_SORT, (rem_reg != '0) && (rem_reg <= fill_reg), "removal count out of range")
    `OLE_ASSERT_NEXT(a_rsp_count, rsp_load, rsp_reg.count == ole_pkg::RES_W'(fill_reg), "response count differs from list fill")

endmodule
